// ===== sv/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg: shared types and constants for the timed MIDI message delay
// Item layouts, queue sizing and MIDI status codes.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PTR_W       = SLOT_W + 1;

  localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
  localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
  localparam logic [6:0] DATA_MAX      = 7'd127;

  // input item: one control tick
  typedef struct packed {
    logic [7:0]  message_kind;
    logic [4:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [15:0] delay_ticks;
  } tmd_in_t;

  // result item: one per tick
  typedef struct packed {
    logic       send_valid;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic       dropped;
  } tmd_out_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic        is_note;
    logic        note_on;
    logic [4:0]  chan0;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [15:0] delay;
  } tmd_cmd_t;

  // queued message as stored in the ring
  typedef struct packed {
    logic                 note_on;
    logic [4:0]           chan0;
    logic [6:0]           first;
    logic [6:0]           second;
    logic [TIME_BITS-1:0] stamp;
  } tmd_entry_t;

  localparam int unsigned ENTRY_W = $bits(tmd_entry_t);

endpackage

// ===== sv/tmd_ram.sv =====
// ----------------------------------------------------------------------------
// tmd_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module tmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tmd_front.sv =====
// ----------------------------------------------------------------------------
// tmd_front: tick intake and classification
// Classify each tick, clamp data bytes and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module tmd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tmd_pkg::tmd_in_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output tmd_pkg::tmd_cmd_t cmd_data_o
);
  import tmd_pkg::*;

  tmd_cmd_t   slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  tmd_cmd_t   cmd_new;
  logic       push, pop;

  // classify and clamp
  always_comb begin
    cmd_new.is_note = (in_data_i.message_kind == KIND_NOTE_ON) ||
                      (in_data_i.message_kind == KIND_NOTE_OFF);
    cmd_new.note_on = (in_data_i.message_kind == KIND_NOTE_ON);
    cmd_new.chan0   = in_data_i.channel - 5'd1;
    cmd_new.first   = in_data_i.note_number[7] ? DATA_MAX : in_data_i.note_number[6:0];
    cmd_new.second  = in_data_i.velocity[7] ? DATA_MAX : in_data_i.velocity[6:0];
    cmd_new.delay   = in_data_i.delay_ticks;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_data_o  = slot_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d  = push ? ~wptr_q : wptr_q;
    rptr_d  = pop ? ~rptr_q : rptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_new;
    end
  end

endmodule

// ===== sv/tmd_back.sv =====
// ----------------------------------------------------------------------------
// tmd_back: ring access and send decision
// Write the tick's message, fetch the queue head, test its age, emit result.
// ----------------------------------------------------------------------------
module tmd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  tmd_pkg::tmd_cmd_t cmd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tmd_pkg::tmd_out_t out_data_o
);
  import tmd_pkg::*;

  localparam logic ST_ACCESS  = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(QUEUE_DEPTH);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] s;
    s = (ptr >= PTR_DEPTH) ? ptr - PTR_DEPTH : ptr;
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  endfunction

  logic                 state_q, state_d;
  logic [PTR_W-1:0]     rd_q, rd_d;
  logic [PTR_W-1:0]     wr_q, wr_d;
  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic                 head_valid_q, head_valid_d;
  logic                 bypass_q, bypass_d;
  logic                 out_valid_q, out_valid_d;
  tmd_entry_t           byp_q;
  logic [15:0]          delay_q;
  logic                 dropped_q;
  tmd_out_t             out_q, out_d;

  logic                 empty, full, do_access, do_write, do_resolve, send;
  tmd_entry_t           wentry, head;
  logic [ENTRY_W-1:0]   rdata;
  logic [TIME_BITS-1:0] age;

  assign empty      = (wr_q == rd_q);
  assign full       = !empty && (slot_of(wr_q) == slot_of(rd_q));
  assign do_access  = (state_q == ST_ACCESS) && cmd_valid_i;
  assign do_write   = do_access && cmd_data_i.is_note && !full;
  assign do_resolve = (state_q == ST_RESOLVE) && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = (state_q == ST_ACCESS);

  always_comb begin
    wentry.note_on = cmd_data_i.note_on;
    wentry.chan0   = cmd_data_i.chan0;
    wentry.first   = cmd_data_i.first;
    wentry.second  = cmd_data_i.second;
    wentry.stamp   = tick_q;
  end

  tmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (slot_of(wr_q)),
    .wdata_i (wentry),
    .re_i    (do_access),
    .raddr_i (slot_of(rd_q)),
    .rdata_o (rdata)
  );

  // an empty queue that takes a write has that write as its head
  assign head = bypass_q ? byp_q : tmd_entry_t'(rdata);
  assign age  = tick_q - head.stamp;
  assign send = head_valid_q && (age >= TIME_BITS'(delay_q));

  always_comb begin
    state_d      = state_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    tick_d       = tick_q;
    head_valid_d = head_valid_q;
    bypass_d     = bypass_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = '0;
    if (do_access) begin
      state_d      = ST_RESOLVE;
      head_valid_d = !empty || do_write;
      bypass_d     = empty && do_write;
      if (do_write) begin
        wr_d = advance(wr_q);
      end
    end
    if (do_resolve) begin
      state_d     = ST_ACCESS;
      out_valid_d = 1'b1;
      tick_d      = tick_q + TIME_BITS'(1);
      out_d.dropped = dropped_q;
      if (send) begin
        rd_d               = advance(rd_q);
        out_d.send_valid   = 1'b1;
        out_d.status_byte  = (head.note_on ? KIND_NOTE_ON : KIND_NOTE_OFF) |
                             {3'b000, head.chan0};
        out_d.data_first   = head.first;
        out_d.data_second  = head.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_ACCESS;
      rd_q         <= '0;
      wr_q         <= '0;
      tick_q       <= '0;
      head_valid_q <= 1'b0;
      bypass_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      tick_q       <= tick_d;
      head_valid_q <= head_valid_d;
      bypass_q     <= bypass_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_access) begin
      byp_q     <= wentry;
      delay_q   <= cmd_data_i.delay;
      dropped_q <= cmd_data_i.is_note && full;
    end
    if (do_resolve) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/timed_midi_message_delay.sv =====
// ----------------------------------------------------------------------------
// timed_midi_message_delay: timestamped delay queue for MIDI note messages
// A tick passes through the front queue, then the back end's access and resolve
// states, into the output register. The back end takes a new tick only after the
// last one's ring write/read and the age test on the registered head entry.
// Reset (async, active low): empty queue, tick count zero, no result pending.
// ----------------------------------------------------------------------------
module timed_midi_message_delay (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tmd_pkg::tmd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tmd_pkg::tmd_out_t out_data_o
);
  import tmd_pkg::*;

  // Front to back channel: one classified tick per item. The front holds up
  // to two ticks so the input side keeps moving while the back end works or
  // waits on a stalled output.
  logic     cmd_valid;
  logic     cmd_ready;
  tmd_cmd_t cmd_data;

  // Front: decode note-on / note-off, convert the channel to zero-based form
  // and clamp both data bytes before queueing. Other status bytes still form
  // a tick, since every tick yields one result and advances time.
  tmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_data_o  (cmd_data)
  );

  // Back: the access state writes a note message into the ring (or drops it when the
  // ring is full) and fetches the oldest entry; the resolve state compares its age
  // to the tick's delay, sends at most one message, advances the tick count
  // and loads the output register. The output register lets the back end start
  // the next tick's access while a result waits; resolve waits until it is taken.
  tmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_data_i  (cmd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/tmd_checker.sv =====
// ----------------------------------------------------------------------------
// tmd_checker: port-level checks for the timed MIDI message delay
// Output hold under stall and result field consistency.
// ----------------------------------------------------------------------------
module tmd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tmd_pkg::tmd_out_t out_data_o
);
  import tmd_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // idle result fields are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_valid |->
      out_data_o.status_byte == 8'd0 && out_data_o.data_first == 7'd0 &&
      out_data_o.data_second == 7'd0)
    else $error("fields set without a send");

  // a sent status byte is a note-on or note-off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_valid |->
      out_data_o.status_byte[7] && !out_data_o.status_byte[6] &&
      !out_data_o.status_byte[5])
    else $error("sent status byte is not a note message");

endmodule

bind timed_midi_message_delay tmd_checker u_tmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
